// ----- src/line_chart_rasterizer_macros.svh -----
// Assertion helpers for the rasterizer. Each expects signals named clock and reset.
`ifndef LINE_CHART_RASTERIZER_MACROS_SVH
`define LINE_CHART_RASTERIZER_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define LCR_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rasterizer check failed");

// The consequent holds in the cycle after the antecedent.
`define LCR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rasterizer check failed");

`endif

// ----- src/lcr_pkg.sv -----
package lcr_pkg;

   localparam int DEF_CANVAS_WIDTH  = 188;
   localparam int DEF_CANVAS_HEIGHT = 86;
   localparam int DEF_MAX_SAMPLES   = 256;
   localparam int DEF_LINE_WIDTH    = 3;

   localparam int PAD_X      = 2;
   localparam int PAD_Y      = 6;
   localparam int FLAT_WIDEN = 5;
   localparam int DOT_STEP   = 6;

   localparam int PRICE_W = 16;
   localparam int COL_W   = 8;
   localparam int ROW_W   = 7;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_READ = 1'b1;

   typedef enum logic [4:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_CLEAR,
      ST_MM_ADDR,
      ST_MM_CMP,
      ST_MM_FIN,
      ST_ROW_ADDR,
      ST_ROW_MUL,
      ST_ROW_DIV,
      ST_ROW_WAIT,
      ST_COL_MUL,
      ST_COL_DIV,
      ST_COL_WAIT,
      ST_FIRST,
      ST_DOTS,
      ST_SETUP,
      ST_PLOT,
      ST_STEP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load_wr;
      logic rd_pixel;
      logic rsp_pixel;
      logic rsp_render;
      logic empty_set;
      logic empty_clr;
      logic clr_step;
      logic idx_clr;
      logic idx_inc;
      logic mm_cmp;
      logic mm_fin;
      logic row_mul;
      logic col_mul;
      logic div_start;
      logic row_take;
      logic col_take;
      logic first_take;
      logic dot_step;
      logic seg_setup;
      logic seg_plot;
      logic seg_step;
      logic count_clr;
   } cmd_type;

   typedef struct packed {
      logic count_lt2;
      logic clr_last;
      logic idx_zero;
      logic idx_last;
      logic div_busy;
      logic dot_last;
      logic k_last;
      logic at_end;
   } status_type;

endpackage

// ----- src/lcr_ram.sv -----
module lcr_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/lcr_div.sv -----
module lcr_div #(
   parameter int NW = 24,
   parameter int DW = 17
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          busy,
   output logic [NW-1:0] quot
);

   localparam int CW = $clog2(NW + 1);

   logic          busy_ff;
   logic [CW-1:0] cnt_ff;
   logic [NW-1:0] q_ff;
   logic [DW-1:0] rem_ff;
   logic [DW-1:0] den_ff;
   logic [DW:0]   part;
   logic          ge;

   assign part = {rem_ff, q_ff[NW-1]};
   assign ge   = part >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CW'(NW);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         q_ff   <= {q_ff[NW-2:0], ge};
         rem_ff <= ge ? DW'(part - {1'b0, den_ff}) : DW'(part);
      end
   end

   assign busy = busy_ff;
   assign quot = q_ff;

endmodule

// ----- src/lcr_ctrl.sv -----
`include "line_chart_rasterizer_macros.svh"

module lcr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_mode,
   input  logic                req_last_sample,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output lcr_pkg::cmd_type    cmd,
   input  lcr_pkg::status_type status
);

   lcr_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff;
   logic accept;

   assign req_ready = (state_ff == lcr_pkg::ST_IDLE) && !rsp_valid_ff;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcr_pkg::ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.rsp_pixel || cmd.rsp_render) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lcr_pkg::ST_INIT: begin
            if (status.clr_last) begin
               state_in = lcr_pkg::ST_IDLE;
            end
         end
         lcr_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_mode == lcr_pkg::MODE_READ) begin
                  state_in = lcr_pkg::ST_READ;
               end else if (req_last_sample) begin
                  state_in = lcr_pkg::ST_CLEAR;
               end
            end
         end
         lcr_pkg::ST_READ: state_in = lcr_pkg::ST_IDLE;
         lcr_pkg::ST_CLEAR: begin
            if (status.clr_last) begin
               state_in = status.count_lt2 ? lcr_pkg::ST_DONE : lcr_pkg::ST_MM_ADDR;
            end
         end
         lcr_pkg::ST_MM_ADDR: state_in = lcr_pkg::ST_MM_CMP;
         lcr_pkg::ST_MM_CMP: begin
            state_in = status.idx_last ? lcr_pkg::ST_MM_FIN : lcr_pkg::ST_MM_ADDR;
         end
         lcr_pkg::ST_MM_FIN: state_in = lcr_pkg::ST_ROW_ADDR;
         lcr_pkg::ST_ROW_ADDR: state_in = lcr_pkg::ST_ROW_MUL;
         lcr_pkg::ST_ROW_MUL: state_in = lcr_pkg::ST_ROW_DIV;
         lcr_pkg::ST_ROW_DIV: state_in = lcr_pkg::ST_ROW_WAIT;
         lcr_pkg::ST_ROW_WAIT: begin
            if (!status.div_busy) begin
               state_in = lcr_pkg::ST_COL_MUL;
            end
         end
         lcr_pkg::ST_COL_MUL: state_in = lcr_pkg::ST_COL_DIV;
         lcr_pkg::ST_COL_DIV: state_in = lcr_pkg::ST_COL_WAIT;
         lcr_pkg::ST_COL_WAIT: begin
            if (!status.div_busy) begin
               state_in = status.idx_zero ? lcr_pkg::ST_FIRST : lcr_pkg::ST_SETUP;
            end
         end
         lcr_pkg::ST_FIRST: state_in = lcr_pkg::ST_DOTS;
         lcr_pkg::ST_DOTS: begin
            if (status.dot_last) begin
               state_in = lcr_pkg::ST_ROW_ADDR;
            end
         end
         lcr_pkg::ST_SETUP: state_in = lcr_pkg::ST_PLOT;
         lcr_pkg::ST_PLOT: begin
            if (status.k_last) begin
               state_in = lcr_pkg::ST_STEP;
            end
         end
         lcr_pkg::ST_STEP: begin
            if (!status.at_end) begin
               state_in = lcr_pkg::ST_PLOT;
            end else if (status.idx_last) begin
               state_in = lcr_pkg::ST_DONE;
            end else begin
               state_in = lcr_pkg::ST_ROW_ADDR;
            end
         end
         lcr_pkg::ST_DONE: state_in = lcr_pkg::ST_IDLE;
         default: state_in = lcr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         lcr_pkg::ST_INIT: cmd.clr_step = 1'b1;
         lcr_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_mode == lcr_pkg::MODE_READ) begin
                  cmd.rd_pixel = 1'b1;
               end else begin
                  cmd.load_wr = 1'b1;
               end
            end
         end
         lcr_pkg::ST_READ: cmd.rsp_pixel = 1'b1;
         lcr_pkg::ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               if (status.count_lt2) begin
                  cmd.empty_set = 1'b1;
               end else begin
                  cmd.empty_clr = 1'b1;
                  cmd.idx_clr   = 1'b1;
               end
            end
         end
         lcr_pkg::ST_MM_CMP: begin
            cmd.mm_cmp  = 1'b1;
            cmd.idx_inc = !status.idx_last;
         end
         lcr_pkg::ST_MM_FIN: begin
            cmd.mm_fin  = 1'b1;
            cmd.idx_clr = 1'b1;
         end
         lcr_pkg::ST_ROW_MUL: cmd.row_mul = 1'b1;
         lcr_pkg::ST_ROW_DIV: cmd.div_start = 1'b1;
         lcr_pkg::ST_ROW_WAIT: cmd.row_take = !status.div_busy;
         lcr_pkg::ST_COL_MUL: cmd.col_mul = 1'b1;
         lcr_pkg::ST_COL_DIV: cmd.div_start = 1'b1;
         lcr_pkg::ST_COL_WAIT: cmd.col_take = !status.div_busy;
         lcr_pkg::ST_FIRST: cmd.first_take = 1'b1;
         lcr_pkg::ST_DOTS: begin
            cmd.dot_step = 1'b1;
            cmd.idx_inc  = status.dot_last;
         end
         lcr_pkg::ST_SETUP: cmd.seg_setup = 1'b1;
         lcr_pkg::ST_PLOT: cmd.seg_plot = 1'b1;
         lcr_pkg::ST_STEP: begin
            if (!status.at_end) begin
               cmd.seg_step = 1'b1;
            end else if (!status.idx_last) begin
               cmd.idx_inc = 1'b1;
            end
         end
         lcr_pkg::ST_DONE: begin
            cmd.rsp_render = 1'b1;
            cmd.count_clr  = 1'b1;
         end
         default: cmd = '0;
      endcase
   end

   `LCR_ASSERT_SAME(a_rsp_source, $rose(rsp_valid_ff), $past(state_ff) == lcr_pkg::ST_READ || $past(state_ff) == lcr_pkg::ST_DONE)
   `LCR_ASSERT_SAME(a_div_free, cmd.div_start, !status.div_busy)
   `LCR_ASSERT_NEXT(a_render_starts, accept && req_mode == lcr_pkg::MODE_LOAD && req_last_sample, state_ff == lcr_pkg::ST_CLEAR)

endmodule

// ----- src/lcr_dp.sv -----
module lcr_dp #(
   parameter int CANVAS_WIDTH  = lcr_pkg::DEF_CANVAS_WIDTH,
   parameter int CANVAS_HEIGHT = lcr_pkg::DEF_CANVAS_HEIGHT,
   parameter int MAX_SAMPLES   = lcr_pkg::DEF_MAX_SAMPLES,
   parameter int LINE_WIDTH    = lcr_pkg::DEF_LINE_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lcr_pkg::cmd_type                  cmd,
   output lcr_pkg::status_type               status,
   input  logic signed [lcr_pkg::PRICE_W-1:0] req_sample_price,
   input  logic [lcr_pkg::COL_W-1:0]         req_pixel_col,
   input  logic [lcr_pkg::ROW_W-1:0]         req_pixel_row,
   output logic                              rsp_pixel_black,
   output logic                              rsp_chart_empty,
   output logic                              rsp_render_done
);

   localparam int PLOT_W = CANVAS_WIDTH - 2 * lcr_pkg::PAD_X;
   localparam int PLOT_H = CANVAS_HEIGHT - 2 * lcr_pkg::PAD_Y;
   localparam int NPIX   = CANVAS_WIDTH * CANVAS_HEIGHT;
   localparam int FAW    = $clog2(NPIX);
   localparam int SAW    = $clog2(MAX_SAMPLES);
   localparam int CNTW   = $clog2(MAX_SAMPLES + 1);
   localparam int PW     = lcr_pkg::PRICE_W + 1;
   localparam int MAXDIM = (CANVAS_WIDTH > CANVAS_HEIGHT) ? CANVAS_WIDTH : CANVAS_HEIGHT;
   localparam int CRW    = $clog2(MAXDIM) + 2;
   localparam int ERW    = CRW + 2;
   localparam int NW_ROW = PW + $clog2(CANVAS_HEIGHT);
   localparam int NW_COL = CNTW + $clog2(CANVAS_WIDTH);
   localparam int NW     = (NW_ROW > NW_COL) ? NW_ROW : NW_COL;
   localparam int DW     = (PW > CNTW) ? PW : CNTW;
   localparam int HALF   = LINE_WIDTH / 2;
   localparam int NT     = 2 * HALF + 1;
   localparam int KMAX   = (LINE_WIDTH > 2) ? 2 * NT : NT;
   localparam int KW     = $clog2(KMAX + 1);
   localparam int DOT_END = CANVAS_WIDTH - lcr_pkg::PAD_X - 2;

   logic [CNTW-1:0] count_ff;
   logic [CNTW-1:0] idx_ff;
   logic            empty_ff;
   logic [FAW-1:0]  clr_addr_ff;
   logic            inb_ff;
   logic signed [PW-1:0] lo_ff, hi_ff;
   logic [PW-1:0]   range_ff;
   logic [NW-1:0]   num_ff;
   logic [DW-1:0]   den_ff;
   logic signed [CRW-1:0] tx_ff, ty_ff, xa_ff, ya_ff, dot_x_ff;
   logic signed [ERW-1:0] dx_ff, dy_ff, err_ff;
   logic            sx_neg_ff, sy_neg_ff;
   logic [KW-1:0]   k_ff;
   logic            pb_ff, ce_ff, rd_ff;

   logic [lcr_pkg::PRICE_W-1:0] smp_rd;
   logic signed [PW-1:0]        smp;
   logic                        smp_wr;
   logic                        div_busy;
   logic [NW-1:0]               quot;
   logic                        frm_rd;
   logic                        frm_we;
   logic [FAW-1:0]              frm_waddr;
   logic                        frm_wdata;
   logic [FAW-1:0]              frm_raddr;
   logic signed [CRW-1:0]       px, py, koff, hoff, xdiff, ydiff;
   logic                        p_in;
   logic signed [ERW-1:0]       e2, err_in, dx_abs, dy_abs;
   logic                        c1, c2, mm_eq;
   logic signed [PW:0]          diff;

   assign smp    = $signed({smp_rd[lcr_pkg::PRICE_W-1], smp_rd});
   assign smp_wr = cmd.load_wr && (count_ff < CNTW'(MAX_SAMPLES));

   lcr_ram #(.WIDTH(lcr_pkg::PRICE_W), .DEPTH(MAX_SAMPLES)) u_samples (
      .clock   (clock),
      .wr_en   (smp_wr),
      .wr_addr (count_ff[SAW-1:0]),
      .wr_data (req_sample_price),
      .rd_addr (idx_ff[SAW-1:0]),
      .rd_data (smp_rd)
   );

   lcr_div #(.NW(NW), .DW(DW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (num_ff),
      .den   (den_ff),
      .busy  (div_busy),
      .quot  (quot)
   );

   assign koff = CRW'(k_ff) - CRW'(HALF);
   assign hoff = CRW'(k_ff) - CRW'(NT + HALF);

   always_comb begin
      if (cmd.dot_step) begin
         px = dot_x_ff;
         py = ya_ff;
      end else if (k_ff < KW'(NT)) begin
         px = xa_ff;
         py = ya_ff + koff;
      end else begin
         px = xa_ff + hoff;
         py = ya_ff;
      end
   end

   assign p_in = !px[CRW-1] && !py[CRW-1] &&
                 ($unsigned(px) < CRW'(CANVAS_WIDTH)) &&
                 ($unsigned(py) < CRW'(CANVAS_HEIGHT));

   always_comb begin
      if (cmd.clr_step) begin
         frm_we    = 1'b1;
         frm_waddr = clr_addr_ff;
         frm_wdata = 1'b0;
      end else begin
         frm_we    = (cmd.dot_step || cmd.seg_plot) && p_in;
         frm_waddr = FAW'($unsigned(py)) * FAW'(CANVAS_WIDTH) + FAW'($unsigned(px));
         frm_wdata = 1'b1;
      end
   end

   assign frm_raddr = FAW'(req_pixel_row) * FAW'(CANVAS_WIDTH) + FAW'(req_pixel_col);

   lcr_ram #(.WIDTH(1), .DEPTH(NPIX)) u_frame (
      .clock   (clock),
      .wr_en   (frm_we),
      .wr_addr (frm_waddr),
      .wr_data (frm_wdata),
      .rd_addr (frm_raddr),
      .rd_data (frm_rd)
   );

   assign mm_eq  = lo_ff == hi_ff;
   assign diff   = (PW+1)'(smp) - (PW+1)'(lo_ff);
   assign xdiff  = tx_ff - xa_ff;
   assign ydiff  = ty_ff - ya_ff;
   assign dx_abs = xdiff[CRW-1] ? -ERW'(xdiff) : ERW'(xdiff);
   assign dy_abs = ydiff[CRW-1] ? -ERW'(ydiff) : ERW'(ydiff);
   assign e2     = err_ff <<< 1;
   assign c1     = e2 >= dy_ff;
   assign c2     = e2 <= dx_ff;
   assign err_in = err_ff + (c1 ? dy_ff : ERW'(0)) + (c2 ? dx_ff : ERW'(0));

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         empty_ff    <= 1'b1;
         clr_addr_ff <= '0;
         idx_ff      <= '0;
         k_ff        <= '0;
      end else begin
         if (smp_wr) begin
            count_ff <= count_ff + CNTW'(1);
         end else if (cmd.count_clr) begin
            count_ff <= '0;
         end
         if (cmd.empty_set) begin
            empty_ff <= 1'b1;
         end else if (cmd.empty_clr) begin
            empty_ff <= 1'b0;
         end
         if (cmd.clr_step) begin
            clr_addr_ff <= status.clr_last ? '0 : clr_addr_ff + FAW'(1);
         end
         if (cmd.idx_clr) begin
            idx_ff <= '0;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_ff + CNTW'(1);
         end
         if (cmd.seg_plot) begin
            k_ff <= status.k_last ? '0 : k_ff + KW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_pixel) begin
         inb_ff <= (req_pixel_col < lcr_pkg::COL_W'(CANVAS_WIDTH)) &&
                   (req_pixel_row < lcr_pkg::ROW_W'(CANVAS_HEIGHT));
      end
      if (cmd.mm_cmp) begin
         if (status.idx_zero || smp < lo_ff) begin
            lo_ff <= smp;
         end
         if (status.idx_zero || smp > hi_ff) begin
            hi_ff <= smp;
         end
      end
      if (cmd.mm_fin) begin
         if (mm_eq) begin
            lo_ff    <= lo_ff - PW'(lcr_pkg::FLAT_WIDEN);
            range_ff <= PW'(2 * lcr_pkg::FLAT_WIDEN);
         end else begin
            range_ff <= PW'(hi_ff - lo_ff);
         end
      end
      if (cmd.row_mul) begin
         num_ff <= NW'(diff[PW-1:0]) * NW'(PLOT_H);
         den_ff <= DW'(range_ff);
      end
      if (cmd.col_mul) begin
         num_ff <= NW'(idx_ff) * NW'(PLOT_W);
         den_ff <= DW'(count_ff - CNTW'(1));
      end
      if (cmd.row_take) begin
         ty_ff <= CRW'(lcr_pkg::PAD_Y + PLOT_H) - CRW'(quot);
      end
      if (cmd.col_take) begin
         tx_ff <= CRW'(lcr_pkg::PAD_X) + CRW'(quot);
      end
      if (cmd.first_take) begin
         xa_ff    <= tx_ff;
         ya_ff    <= ty_ff;
         dot_x_ff <= CRW'(lcr_pkg::PAD_X + 2);
      end
      if (cmd.dot_step) begin
         dot_x_ff <= dot_x_ff + CRW'(lcr_pkg::DOT_STEP);
      end
      if (cmd.seg_setup) begin
         dx_ff     <= dx_abs;
         dy_ff     <= -dy_abs;
         err_ff    <= dx_abs - dy_abs;
         sx_neg_ff <= !(xa_ff < tx_ff);
         sy_neg_ff <= !(ya_ff < ty_ff);
      end
      if (cmd.seg_step) begin
         err_ff <= err_in;
         if (c1) begin
            xa_ff <= sx_neg_ff ? xa_ff - CRW'(1) : xa_ff + CRW'(1);
         end
         if (c2) begin
            ya_ff <= sy_neg_ff ? ya_ff - CRW'(1) : ya_ff + CRW'(1);
         end
      end
      if (cmd.rsp_pixel) begin
         pb_ff <= inb_ff & frm_rd;
         ce_ff <= empty_ff;
         rd_ff <= 1'b0;
      end else if (cmd.rsp_render) begin
         pb_ff <= 1'b0;
         ce_ff <= empty_ff;
         rd_ff <= 1'b1;
      end
   end

   assign status.count_lt2 = count_ff < CNTW'(2);
   assign status.clr_last  = clr_addr_ff == FAW'(NPIX - 1);
   assign status.idx_zero  = idx_ff == '0;
   assign status.idx_last  = CNTW'(idx_ff + CNTW'(1)) == count_ff;
   assign status.div_busy  = div_busy;
   assign status.dot_last  = (dot_x_ff + CRW'(lcr_pkg::DOT_STEP)) >= CRW'(DOT_END);
   assign status.k_last    = k_ff == KW'(KMAX - 1);
   assign status.at_end    = (xa_ff == tx_ff) && (ya_ff == ty_ff);

   assign rsp_pixel_black = pb_ff;
   assign rsp_chart_empty = ce_ff;
   assign rsp_render_done = rd_ff;

endmodule

// ----- src/line_chart_rasterizer.sv -----
// Line chart rasterizer. After reset the block clears its frame memory to white, one pixel per
// cycle over all CANVAS_WIDTH * CANVAS_HEIGHT pixels (16168 at the defaults), and holds its
// input off until that is done. A load word (mode 0) stores one signed price sample and gives
// no response unless it carries last_sample; a read word (mode 1) returns one canvas pixel
// through the registered read of the frame memory and the registered response. A last sample
// starts a render that stalls the input until its single response word: first a clearing pass
// over the whole frame memory, then a min/max scan over the samples, then per sample two passes
// of the shared bit-serial divider, the baseline dots after the first sample, and, with
// T = 2 * (LINE_WIDTH / 2) + 1 pixels across the line, T pixels down and T across (only the T
// down for widths below three) at each point walked along each line segment, all through the
// one-pixel-per-cycle frame write port. A chart with fewer than two samples responds right
// after the clear.
module line_chart_rasterizer #(
   parameter int CANVAS_WIDTH  = lcr_pkg::DEF_CANVAS_WIDTH,
   parameter int CANVAS_HEIGHT = lcr_pkg::DEF_CANVAS_HEIGHT,
   parameter int MAX_SAMPLES   = lcr_pkg::DEF_MAX_SAMPLES,
   parameter int LINE_WIDTH    = lcr_pkg::DEF_LINE_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_mode,
   input  logic signed [lcr_pkg::PRICE_W-1:0] req_sample_price,
   input  logic                               req_last_sample,
   input  logic [lcr_pkg::COL_W-1:0]          req_pixel_col,
   input  logic [lcr_pkg::ROW_W-1:0]          req_pixel_row,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_pixel_black,
   output logic                               rsp_chart_empty,
   output logic                               rsp_render_done
);

   lcr_pkg::cmd_type    cmd;
   lcr_pkg::status_type status;

   lcr_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_mode        (req_mode),
      .req_last_sample (req_last_sample),
      .req_ready       (req_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .cmd             (cmd),
      .status          (status)
   );

   lcr_dp #(
      .CANVAS_WIDTH  (CANVAS_WIDTH),
      .CANVAS_HEIGHT (CANVAS_HEIGHT),
      .MAX_SAMPLES   (MAX_SAMPLES),
      .LINE_WIDTH    (LINE_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_sample_price (req_sample_price),
      .req_pixel_col    (req_pixel_col),
      .req_pixel_row    (req_pixel_row),
      .rsp_pixel_black  (rsp_pixel_black),
      .rsp_chart_empty  (rsp_chart_empty),
      .rsp_render_done  (rsp_render_done)
   );

endmodule

// ----- dv/tb_line_chart_rasterizer.sv -----
module tb_line_chart_rasterizer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW = lcr_pkg::DEF_CANVAS_WIDTH;
   localparam int CH = lcr_pkg::DEF_CANVAS_HEIGHT;
   localparam int MAXS = lcr_pkg::DEF_MAX_SAMPLES;
   localparam int LW = lcr_pkg::DEF_LINE_WIDTH;

   typedef struct {
      bit pixel_black;
      bit chart_empty;
      bit render_done;
   } pixel_word_type;

   class chart_scoreboard;
      shortint series[MAXS];
      int n_loaded;
      bit canvas[CW * CH];
      bit empty_flag;
      pixel_word_type pending[$];

      function new();
         n_loaded = 0;
         empty_flag = 1'b1;
         foreach (canvas[i]) canvas[i] = 1'b0;
      endfunction

      function void dot(int x, int y);
         if (x < 0 || y < 0 || x >= CW || y >= CH) return;
         canvas[y * CW + x] = 1'b1;
      endfunction

      function int row_of(int p, int lo, int range, int ph);
         longint s;
         s = (longint'(p - lo) * ph) / range;
         return lcr_pkg::PAD_Y + ph - int'(s);
      endfunction

      function void segment(int xa, int ya, int xb, int yb);
         int dx, dy, sx, sy, err, e2, half;
         dx = (xb > xa) ? xb - xa : xa - xb;
         dy = (yb > ya) ? ya - yb : yb - ya;
         sx = (xa < xb) ? 1 : -1;
         sy = (ya < yb) ? 1 : -1;
         err = dx + dy;
         half = LW / 2;
         forever begin
            for (int t = -half; t <= half; t++) begin
               dot(xa, ya + t);
               if (LW > 2) dot(xa + t, ya);
            end
            if (xa == xb && ya == yb) break;
            e2 = 2 * err;
            if (e2 >= dy) begin
               err += dy;
               xa += sx;
            end
            if (e2 <= dx) begin
               err += dx;
               ya += sy;
            end
         end
      endfunction

      function void render_chart();
         int lo, hi, range, pw, ph, base;
         foreach (canvas[i]) canvas[i] = 1'b0;
         if (n_loaded < 2) begin
            empty_flag = 1'b1;
            return;
         end
         empty_flag = 1'b0;
         lo = series[0];
         hi = series[0];
         for (int i = 1; i < n_loaded; i++) begin
            if (series[i] < lo) lo = series[i];
            if (series[i] > hi) hi = series[i];
         end
         if (lo == hi) begin
            lo -= lcr_pkg::FLAT_WIDEN;
            hi += lcr_pkg::FLAT_WIDEN;
         end
         range = hi - lo;
         pw = CW - 2 * lcr_pkg::PAD_X;
         ph = CH - 2 * lcr_pkg::PAD_Y;
         base = row_of(series[0], lo, range, ph);
         for (int x = lcr_pkg::PAD_X + 2; x < CW - lcr_pkg::PAD_X - 2; x += lcr_pkg::DOT_STEP)
            dot(x, base);
         for (int i = 1; i < n_loaded; i++)
            segment(lcr_pkg::PAD_X + (i - 1) * pw / (n_loaded - 1),
                    row_of(series[i - 1], lo, range, ph),
                    lcr_pkg::PAD_X + i * pw / (n_loaded - 1),
                    row_of(series[i], lo, range, ph));
      endfunction

      function void note_word(bit mode, shortint price, bit last, int col, int row);
         pixel_word_type w;
         if (mode == lcr_pkg::MODE_LOAD) begin
            if (n_loaded < MAXS) begin
               series[n_loaded] = price;
               n_loaded++;
            end
            if (!last) return;
            render_chart();
            n_loaded = 0;
            w.pixel_black = 1'b0;
            w.render_done = 1'b1;
         end else begin
            w.pixel_black = (col < CW && row < CH) ? canvas[row * CW + col] : 1'b0;
            w.render_done = 1'b0;
         end
         w.chart_empty = empty_flag;
         pending.push_back(w);
      endfunction

      function string check_word(bit pix, bit emp, bit done);
         pixel_word_type w;
         if (pending.size() == 0) return "response word with none expected";
         w = pending.pop_front();
         if (w.pixel_black !== pix || w.chart_empty !== emp || w.render_done !== done)
            return $sformatf("got black=%0b empty=%0b done=%0b, expected %0b %0b %0b",
                             pix, emp, done, w.pixel_black, w.chart_empty, w.render_done);
         return "";
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_mode = 1'b0;
   logic signed [lcr_pkg::PRICE_W-1:0] req_sample_price = '0;
   logic req_last_sample = 1'b0;
   logic [lcr_pkg::COL_W-1:0] req_pixel_col = '0;
   logic [lcr_pkg::ROW_W-1:0] req_pixel_row = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_pixel_black;
   logic rsp_chart_empty;
   logic rsp_render_done;

   chart_scoreboard chart_sb = new();
   int errors = 0;
   int hold_cycles = 0;
   int words_sent = 0;

   always #5 clock = ~clock;

   line_chart_rasterizer dut (.*);

   task automatic report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(posedge clock) begin
      string msg;
      if (!reset && rsp_valid && rsp_ready) begin
         msg = chart_sb.check_word(rsp_pixel_black, rsp_chart_empty, rsp_render_done);
         if (msg != "") report(msg);
      end
   end

   initial begin
      int gap;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_cycles--;
         end else if (gap > 0) begin
            rsp_ready <= 1'b0;
            gap--;
         end else begin
            rsp_ready <= 1'b1;
            gap = pick_gap();
         end
      end
   end

   task automatic send_word(bit mode, shortint price, bit last, int col, int row,
                            bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_sample_price <= price;
      req_last_sample <= last;
      req_pixel_col <= col;
      req_pixel_row <= row;
      do @(posedge clock); while (!req_ready);
      chart_sb.note_word(mode, price, last, col, row);
      words_sent++;
   endtask

   task automatic load_series(int len, int base, int spread);
      int p;
      for (int i = 0; i < len; i++) begin
         if (spread < 0) p = $signed(16'($urandom()));
         else p = base + $urandom_range(0, spread);
         if (p > 32767) p = 32767;
         if (p < -32768) p = -32768;
         send_word(lcr_pkg::MODE_LOAD, shortint'(p), i == len - 1, $urandom_range(0, 255),
                   $urandom_range(0, 127));
      end
   endtask

   task automatic read_pixels(int count);
      int c, r;
      for (int i = 0; i < count; i++) begin
         c = ($urandom_range(0, 9) < 8) ? $urandom_range(0, CW - 1) : $urandom_range(0, 255);
         r = ($urandom_range(0, 9) < 8) ? $urandom_range(0, CH - 1) : $urandom_range(0, 127);
         send_word(lcr_pkg::MODE_READ, shortint'($urandom()), $urandom_range(0, 1), c, r);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (chart_sb.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      int len, kind;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_word(lcr_pkg::MODE_READ, 16'sd0, 1'b0, 0, 0);
      send_word(lcr_pkg::MODE_READ, -16'sd1, 1'b1, 255, 127);
      send_word(lcr_pkg::MODE_READ, 16'sd0, 1'b0, CW - 1, CH - 1);
      send_word(lcr_pkg::MODE_LOAD, 16'sd100, 1'b1, 0, 0);
      send_word(lcr_pkg::MODE_READ, 16'sd0, 1'b0, 4, 43);
      load_series(3, 500, 0);
      read_pixels(4);
      send_word(lcr_pkg::MODE_LOAD, -16'sd32768, 1'b0, 0, 0);
      send_word(lcr_pkg::MODE_LOAD, 16'sd32767, 1'b0, 0, 0);
      send_word(lcr_pkg::MODE_LOAD, -16'sd32768, 1'b1, 0, 0);
      send_word(lcr_pkg::MODE_READ, 16'sd0, 1'b0, 2, 80);
      send_word(lcr_pkg::MODE_READ, 16'sd0, 1'b0, 96, 6);
      load_series(MAXS + 20, -200, 400);
      read_pixels(3);

      drain();
      hold_cycles = 300;
      read_pixels(60);
      drain();

      while (words_sent < 1600) begin
         kind = $urandom_range(0, 19);
         if (kind == 0) len = $urandom_range(0, 1);
         else if (kind == 1) len = $urandom_range(40, MAXS + 10);
         else len = $urandom_range(2, 12);
         if (len == 0) send_word(lcr_pkg::MODE_LOAD, shortint'($urandom()), 1'b1, 0, 0);
         else if ($urandom_range(0, 2) == 0) load_series(len, 0, -1);
         else load_series(len, int'($signed(16'($urandom()))) / 2, $urandom_range(0, 60));
         read_pixels($urandom_range(30, 80));
         if ($urandom_range(0, 9) == 0) drain();
      end

      req_valid <= 1'b0;
      drain();
      repeat (20) @(posedge clock);
      if (errors == 0 && chart_sb.pending.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #50ms;
      $display("tb: failure");
      $finish;
   end
endmodule

// ----- filelist.f -----
+incdir+src
src/lcr_pkg.sv
src/lcr_ram.sv
src/lcr_div.sv
src/lcr_ctrl.sv
src/lcr_dp.sv
src/line_chart_rasterizer.sv
dv/tb_line_chart_rasterizer.sv
